/* hw/rtl/fbsa_pkg.sv */
// Shared constants, codes and types of the fixed block stack allocator.
package fbsa_pkg;

  // Default configuration of the pool
  localparam int unsigned BLOCK_TOTAL_DEF  = 8192;
  localparam int unsigned BLOCK_BYTES_DEF  = 2048;
  localparam int unsigned ADDRESS_BITS_DEF = 48;

  // Fixed field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BYTES_W  = 25;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

  // Status and byte totals of one result
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTES_W-1:0]  reserved;
    logic [BYTES_W-1:0]  avail;
  } fbsa_info_t;

endpackage

/* hw/rtl/fbsa_req_if.sv */
// Request channel of the allocator: action, size and address.
interface fbsa_req_if import fbsa_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [ACTION_W-1:0]     action;
  logic [SIZE_W-1:0]       request_size;
  logic [ADDRESS_BITS-1:0] address_in;

  modport source (output valid, action, request_size, address_in, input ready);
  modport sink   (input valid, action, request_size, address_in, output ready);
endinterface

/* hw/rtl/fbsa_rsp_if.sv */
// Response channel of the allocator: granted address, status and byte totals.
interface fbsa_rsp_if import fbsa_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [ADDRESS_BITS-1:0] granted_address;
  logic [STATUS_W-1:0]     status;
  logic [BYTES_W-1:0]      reserved_bytes;
  logic [BYTES_W-1:0]      free_bytes;

  modport source (output valid, granted_address, status, reserved_bytes, free_bytes,
                  input ready);
  modport sink   (input valid, granted_address, status, reserved_bytes, free_bytes,
                  output ready);
endinterface

/* hw/rtl/fbsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fbsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* hw/rtl/fbsa_ctrl.sv */
// Allocator control: stack pointer, byte totals, init sweep and RAM access.
module fbsa_ctrl import fbsa_pkg::*; #(
  parameter int unsigned BLOCK_TOTAL  = BLOCK_TOTAL_DEF,
  parameter int unsigned BLOCK_BYTES  = BLOCK_BYTES_DEF,
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF,
  localparam int unsigned IDX_W       = $clog2(BLOCK_TOTAL),
  localparam int unsigned CNT_W       = $clog2(BLOCK_TOTAL + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request side
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  logic [ACTION_W-1:0]     req_action_i,
  input  logic [SIZE_W-1:0]       req_size_i,
  input  logic [ADDRESS_BITS-1:0] req_addr_i,
  // result side
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output logic [ADDRESS_BITS-1:0] res_addr_o,
  output fbsa_info_t              res_info_o,
  // stack memory
  output logic                    mem_we_o,
  output logic [IDX_W-1:0]        mem_waddr_o,
  output logic [ADDRESS_BITS-1:0] mem_wdata_o,
  output logic                    mem_re_o,
  output logic [IDX_W-1:0]        mem_raddr_o,
  input  logic [ADDRESS_BITS-1:0] mem_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;
  localparam logic [1:0] S_INIT = 2'd3;

  localparam logic [CNT_W-1:0]        CntFull   = CNT_W'(BLOCK_TOTAL);
  localparam logic [IDX_W-1:0]        IdxLast   = IDX_W'(BLOCK_TOTAL - 1);
  localparam logic [SIZE_W-1:0]       SizeMax   = SIZE_W'(BLOCK_BYTES);
  localparam logic [BYTES_W-1:0]      BlkBytes  = BYTES_W'(BLOCK_BYTES);
  localparam logic [ADDRESS_BITS-1:0] AddrStep  = ADDRESS_BITS'(BLOCK_BYTES);
  localparam logic [BYTES_W-1:0]      PoolBytes =
    BYTES_W'(64'(BLOCK_TOTAL) * 64'(BLOCK_BYTES));

  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_m1;
  logic [BYTES_W-1:0]      rsv_q, rsv_d, fre_q, fre_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [ADDRESS_BITS-1:0] base_q, base_d;
  logic [ADDRESS_BITS-1:0] hold_addr_q, hold_addr_d;
  fbsa_info_t              info_q, info_d, info_new;
  logic                    read_go, init_go;

  assign req_ready_o = (state_q == S_IDLE);
  assign cnt_m1      = cnt_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rsv_d       = rsv_q;
    fre_d       = fre_q;
    idx_d       = idx_q;
    base_d      = base_q;
    hold_addr_d = hold_addr_q;
    info_d      = info_q;
    info_new    = '{status: ST_DONE, reserved: rsv_q, avail: fre_q};
    read_go     = 1'b0;
    init_go     = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = base_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q[IDX_W-1:0];
    res_valid_o = 1'b0;
    res_addr_o  = hold_addr_q;
    res_info_o  = info_q;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          case (req_action_i)
            ACT_ALLOC: begin
              if (req_size_i > SizeMax) begin
                info_new.status = ST_TOO_LARGE;
              end else if (cnt_q >= CntFull) begin
                info_new.status = ST_EMPTY;
              end else begin
                read_go           = 1'b1;
                mem_re_o          = 1'b1;
                cnt_d             = cnt_q + 1'b1;
                info_new.reserved = rsv_q + BlkBytes;
                info_new.avail    = fre_q - BlkBytes;
              end
            end
            ACT_FREE: begin
              if (cnt_q != '0) begin
                mem_we_o          = 1'b1;
                mem_waddr_o       = cnt_m1[IDX_W-1:0];
                mem_wdata_o       = req_addr_i;
                cnt_d             = cnt_m1;
                info_new.reserved = rsv_q - BlkBytes;
                info_new.avail    = fre_q + BlkBytes;
              end else begin
                info_new.status = ST_IGNORED;
              end
            end
            ACT_INIT: begin
              init_go = 1'b1;
              base_d  = req_addr_i;
              idx_d   = '0;
              state_d = S_INIT;
            end
            default: begin
              info_new.status = ST_IGNORED;
            end
          endcase
          rsv_d = info_new.reserved;
          fre_d = info_new.avail;
          if (read_go) begin
            info_d  = info_new;
            state_d = S_RD;
          end else if (!init_go) begin
            // result known at once: pass it on, or hold it if the slot is taken
            res_valid_o = 1'b1;
            res_addr_o  = '0;
            res_info_o  = info_new;
            if (!res_ready_i) begin
              hold_addr_d = '0;
              info_d      = info_new;
              state_d     = S_HOLD;
            end
          end
        end
      end
      S_RD: begin
        res_valid_o = 1'b1;
        res_addr_o  = mem_rdata_i;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end else begin
          hold_addr_d = mem_rdata_i;
          state_d     = S_HOLD;
        end
      end
      S_HOLD: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_INIT: begin
        mem_we_o = 1'b1;
        base_d   = base_q + AddrStep;
        idx_d    = idx_q + 1'b1;
        if (idx_q == IdxLast) begin
          cnt_d       = '0;
          rsv_d       = '0;
          fre_d       = PoolBytes;
          hold_addr_d = '0;
          info_d      = '{status: ST_DONE, reserved: '0, avail: PoolBytes};
          state_d     = S_HOLD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CntFull;
      rsv_q   <= PoolBytes;
      fre_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rsv_q   <= rsv_d;
      fre_q   <= fre_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    base_q      <= base_d;
    hold_addr_q <= hold_addr_d;
    info_q      <= info_d;
  end

endmodule

/* hw/rtl/fixed_block_stack_allocator_core.sv */
// Top level of the fixed block stack allocator: control, stack RAM, output register.
//
// Fixed-size block allocator over a stack of free block addresses held in one
// synchronous RAM of BLOCK_TOTAL entries. An initialise beat writes entry i with
// base + i * BLOCK_BYTES (wrapping at ADDRESS_BITS) and empties the allocation
// count; allocate pops the next address when the request fits one block; free
// pushes the given address back, unchecked, when any block is out. Every request
// beat yields exactly one response beat with the granted address (zero unless an
// allocate succeeded), a status and the reserved and free byte totals after the
// step (taken modulo 2^25). After reset the pool counts as fully handed out, so
// issue an initialise before the first allocate; the stack RAM is not cleared and
// needs no clearing pass. Free, failed allocate and unused action codes settle
// their result in the accepting state; a successful allocate hands its address
// on from the read state, once the registered read data of the stack RAM is
// there; initialise sweeps one RAM entry per cycle through the single write
// port, after the accepting state and before the hold state that hands its
// response on. The core handles one request at a time, but accepts the next
// request while a response still waits in the output register.
module fixed_block_stack_allocator_core import fbsa_pkg::*; #(
  parameter int unsigned BLOCK_TOTAL  = BLOCK_TOTAL_DEF,
  parameter int unsigned BLOCK_BYTES  = BLOCK_BYTES_DEF,
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbsa_req_if.sink   req_i,
  fbsa_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = $clog2(BLOCK_TOTAL);

  // control <-> output register
  logic                    res_valid, res_ready;
  logic [ADDRESS_BITS-1:0] res_addr;
  fbsa_info_t              res_info;

  // control <-> stack RAM
  logic                    mem_we, mem_re;
  logic [IDX_W-1:0]        mem_waddr, mem_raddr;
  logic [ADDRESS_BITS-1:0] mem_wdata, mem_rdata;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [ADDRESS_BITS-1:0] out_addr_q;
  fbsa_info_t              out_info_q;
  logic                    out_load;

  fbsa_ctrl #(
    .BLOCK_TOTAL  (BLOCK_TOTAL),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_action_i (req_i.action),
    .req_size_i   (req_i.request_size),
    .req_addr_i   (req_i.address_in),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_addr_o   (res_addr),
    .res_info_o   (res_info),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Stack of free block addresses
  fbsa_ram #(
    .WIDTH (ADDRESS_BITS),
    .DEPTH (BLOCK_TOTAL)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The slot takes a new beat when empty or when its beat leaves this cycle
  assign res_ready = !out_valid_q || rsp_o.ready;
  assign out_load  = res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload until the beat is taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_addr_q <= res_addr;
      out_info_q <= res_info;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.granted_address = out_addr_q;
  assign rsp_o.status          = out_info_q.status;
  assign rsp_o.reserved_bytes  = out_info_q.reserved;
  assign rsp_o.free_bytes      = out_info_q.avail;

endmodule
